// ----- rtl/hhp_pkg.sv -----
// Shared types and constants of the Huffman histogram and packer unit.
// Depends on nothing; the top level, hhp_histogram, hhp_bitpack and hhp_emitter import it.
package hhp_pkg;

	localparam int SYM_W        = 8;
	localparam int SYMBOL_COUNT = 256;
	localparam int MAX_CODE_LEN = 32;
	localparam int COUNT_BITS   = 32;
	localparam int CODE_LEN_W   = 6;
	localparam int ACC_W        = 7;
	localparam int COMB_W       = ACC_W + MAX_CODE_LEN;
	localparam int BUF_W        = COMB_W - ACC_W;
	localparam int TOTAL_W      = 6;
	localparam int REM_W        = 3;
	localparam int CODE_ENTRY_W = CODE_LEN_W + MAX_CODE_LEN;

	typedef enum logic [1:0] {
		OP_COUNT  = 2'd0,
		OP_LOAD   = 2'd1,
		OP_ENCODE = 2'd2,
		OP_FLUSH  = 2'd3
	} op_t;

	localparam logic KIND_COUNT = 1'b0;
	localparam logic KIND_BYTE  = 1'b1;

	typedef struct packed {
		op_t                     op;
		logic [SYM_W-1:0]        symbol;
		logic [MAX_CODE_LEN-1:0] code_value;
		logic [CODE_LEN_W-1:0]   code_length;
	} in_word_t;

	typedef struct packed {
		logic                  kind;
		logic [7:0]            data_byte;
		logic [COUNT_BITS-1:0] count_value;
		logic                  last;
	} out_word_t;

	typedef struct packed {
		logic                  kind;
		logic [COMB_W-1:0]     bits;
		logic [TOTAL_W-1:0]    total;
		logic [COUNT_BITS-1:0] count;
	} pack_item_t;

endpackage

// ----- rtl/huffman_histogram_and_packer_unit.sv -----
// Top level of the Huffman histogram and packer unit.
// Depends on hhp_pkg, hhp_ram, hhp_histogram, hhp_bitpack and hhp_emitter.
//
// One word carries one operation: count, load_code, encode or flush. Words are
// accepted one per cycle; load_code never holds the input back, and a count
// report passes stage 1 and the emitter's s2 and s3 registers. An encode that
// completes n bytes (0 to 4) and a flush that emits a byte hold the output
// register for each of their bytes in turn, and the input stalls only once the
// two-entry result pipeline ahead of that register is full, so while result_stall
// is low the sustained rate is one word per cycle or one output byte per cycle,
// whichever is slower. The occurrence counters live in a 256-entry RAM whose
// entries read as zero until first written, so no clearing pass follows reset;
// repeated counts of one symbol in consecutive cycles are forwarded. Encoding a
// symbol whose code was never loaded gives undefined bytes.
module huffman_histogram_and_packer_unit
	import hhp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_word_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_word_t result
);

	logic                    accept;
	logic                    valid_s1;
	op_t                     op_s1;
	logic [SYM_W-1:0]        symbol_s1;
	logic                    adv_s1;
	logic                    emits_s1;
	logic                    pack_op_s1;
	logic [CODE_LEN_W-1:0]   len_sat;
	logic [CODE_ENTRY_W-1:0] code_entry;
	logic [COUNT_BITS-1:0]   new_count;
	logic [COMB_W-1:0]       pack_bits;
	logic [TOTAL_W-1:0]      pack_total;
	logic                    has_bytes;
	logic                    em_ready;
	pack_item_t              em_item;

	assign accept     = item_valid && !item_stall;
	assign pack_op_s1 = (op_s1 == OP_ENCODE) || (op_s1 == OP_FLUSH);
	assign emits_s1   = (op_s1 == OP_COUNT) || (pack_op_s1 && has_bytes);
	assign adv_s1     = valid_s1 && (!emits_s1 || em_ready);
	assign item_stall = valid_s1 && !adv_s1;
	assign len_sat    = (item.code_length > CODE_LEN_W'(MAX_CODE_LEN))
		? CODE_LEN_W'(MAX_CODE_LEN) : item.code_length;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv_s1) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= item.op;
			symbol_s1 <= item.symbol;
		end
	end

	hhp_ram #(
		.ADDR_W(SYM_W),
		.DATA_W(CODE_ENTRY_W)
	) u_code_ram (
		.clk    (clk),
		.wr_en  (accept && item.op == OP_LOAD),
		.wr_addr(item.symbol),
		.wr_data({len_sat, item.code_value}),
		.rd_en  (accept && item.op == OP_ENCODE),
		.rd_addr(item.symbol),
		.rd_data(code_entry)
	);

	hhp_histogram u_histogram (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept && item.op == OP_COUNT),
		.rd_addr  (item.symbol),
		.upd_en   (adv_s1 && op_s1 == OP_COUNT),
		.upd_addr (symbol_s1),
		.new_count(new_count)
	);

	hhp_bitpack u_bitpack (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv_s1 && pack_op_s1),
		.is_flush (op_s1 == OP_FLUSH),
		.code_word(code_entry[MAX_CODE_LEN-1:0]),
		.code_len (code_entry[CODE_ENTRY_W-1:MAX_CODE_LEN]),
		.bits     (pack_bits),
		.total    (pack_total),
		.has_bytes(has_bytes)
	);

	always_comb begin
		em_item.kind  = (op_s1 == OP_COUNT) ? KIND_COUNT : KIND_BYTE;
		em_item.bits  = pack_bits;
		em_item.total = pack_total;
		em_item.count = new_count;
	end

	hhp_emitter u_emitter (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (valid_s1 && emits_s1),
		.in_item     (em_item),
		.in_ready    (em_ready),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

// ----- rtl/hhp_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module hhp_ram #(
	parameter int ADDR_W = 8,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [1 << ADDR_W];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/hhp_histogram.sv -----
// Symbol occurrence counters: count RAM, per-entry valid bits, saturating
// read-modify-write with forwarding. Depends on hhp_pkg and hhp_ram.
module hhp_histogram
	import hhp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [SYM_W-1:0]      rd_addr,
	input  logic                  upd_en,
	input  logic [SYM_W-1:0]      upd_addr,
	output logic [COUNT_BITS-1:0] new_count
);

	logic [SYMBOL_COUNT-1:0] vld_q;
	logic                    rd_vld_q;
	logic                    fwd_hit_q;
	logic [COUNT_BITS-1:0]   fwd_data_q;
	logic [COUNT_BITS-1:0]   ram_data;
	logic [COUNT_BITS-1:0]   cur_count;

	hhp_ram #(
		.ADDR_W(SYM_W),
		.DATA_W(COUNT_BITS)
	) u_ram (
		.clk    (clk),
		.wr_en  (upd_en),
		.wr_addr(upd_addr),
		.wr_data(new_count),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(ram_data)
	);

	always_comb begin
		if (fwd_hit_q) begin
			cur_count = fwd_data_q;
		end else if (rd_vld_q) begin
			cur_count = ram_data;
		end else begin
			cur_count = '0;
		end
		new_count = (cur_count == '1) ? cur_count : cur_count + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_q  <= 1'b0;
			fwd_hit_q <= 1'b0;
		end else begin
			if (upd_en) begin
				vld_q[upd_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q  <= vld_q[rd_addr];
				fwd_hit_q <= upd_en && (upd_addr == rd_addr);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_data_q <= new_count;
		end
	end

	// The forwarded value always comes from a write in the cycle of the read.
	a_fwd_src: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && upd_en && (upd_addr == rd_addr) |=> fwd_hit_q)
		else $error("hhp_histogram: same-entry write was not forwarded");

endmodule

// ----- rtl/hhp_bitpack.sv -----
// Bit accumulator of the packer: merges pending bits with a code word or
// pads them for a flush. Depends on hhp_pkg.
module hhp_bitpack
	import hhp_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  logic                    is_flush,
	input  logic [MAX_CODE_LEN-1:0] code_word,
	input  logic [CODE_LEN_W-1:0]   code_len,
	output logic [COMB_W-1:0]       bits,
	output logic [TOTAL_W-1:0]      total,
	output logic                    has_bytes
);

	logic [ACC_W-1:0]        acc_q;
	logic [2:0]              held_q;
	logic [MAX_CODE_LEN-1:0] code_mask;
	logic [ACC_W-1:0]        keep_mask;

	always_comb begin
		if (code_len >= CODE_LEN_W'(MAX_CODE_LEN)) begin
			code_mask = '1;
		end else begin
			code_mask = (MAX_CODE_LEN'(1) << code_len) - MAX_CODE_LEN'(1);
		end
		if (is_flush) begin
			bits  = {{MAX_CODE_LEN{1'b0}}, acc_q} << (4'd8 - {1'b0, held_q});
			total = (held_q == 3'd0) ? TOTAL_W'(0) : TOTAL_W'(8);
		end else begin
			bits  = ({{MAX_CODE_LEN{1'b0}}, acc_q} << code_len)
				| {{ACC_W{1'b0}}, code_word & code_mask};
			total = {{(TOTAL_W-3){1'b0}}, held_q} + code_len;
		end
		has_bytes = (total[TOTAL_W-1:3] != '0);
		keep_mask = (ACC_W'(1) << total[2:0]) - ACC_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			held_q <= '0;
		end else if (adv) begin
			if (is_flush) begin
				acc_q  <= '0;
				held_q <= '0;
			end else begin
				acc_q  <= bits[ACC_W-1:0] & keep_mask;
				held_q <= total[2:0];
			end
		end
	end

	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		adv && is_flush |=> held_q == 3'd0 && acc_q == '0)
		else $error("hhp_bitpack: flush left bits pending");

endmodule

// ----- rtl/hhp_emitter.sv -----
// Result emitter: aligns a packed item and hands out its bytes or its count
// report one word per cycle while result_stall is low. Depends on hhp_pkg.
module hhp_emitter
	import hhp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  pack_item_t in_item,
	output logic       in_ready,
	output logic       result_valid,
	input  logic       result_stall,
	output out_word_t  result
);

	logic                  valid_s2;
	pack_item_t            item_s2;
	logic                  valid_s3;
	logic                  kind_s3;
	logic [BUF_W-1:0]      buf_s3;
	logic [REM_W-1:0]      rem_s3;
	logic [COUNT_BITS-1:0] count_s3;
	logic                  s3_take;
	logic                  s3_shift;
	logic [COMB_W-1:0]     aligned;
	logic [REM_W-1:0]      rem_load;

	assign s3_take  = !valid_s3 || (!result_stall && rem_s3 == REM_W'(1));
	assign s3_shift = valid_s3 && !result_stall && rem_s3 != REM_W'(1);
	assign in_ready = !valid_s2 || s3_take;

	always_comb begin
		aligned  = item_s2.bits << (TOTAL_W'(COMB_W) - item_s2.total);
		rem_load = (item_s2.kind == KIND_BYTE) ? item_s2.total[TOTAL_W-1:3] : REM_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			rem_s3   <= '0;
		end else begin
			if (in_ready) begin
				valid_s2 <= in_valid;
			end
			if (s3_take) begin
				valid_s3 <= valid_s2;
				rem_s3   <= valid_s2 ? rem_load : REM_W'(0);
			end else if (s3_shift) begin
				rem_s3 <= rem_s3 - REM_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s2 <= in_item;
		end
		if (s3_take && valid_s2) begin
			kind_s3  <= item_s2.kind;
			buf_s3   <= aligned[COMB_W-1:ACC_W];
			count_s3 <= item_s2.count;
		end else if (s3_shift) begin
			buf_s3 <= buf_s3 << 8;
		end
	end

	always_comb begin
		result_valid       = valid_s3;
		result.kind        = kind_s3;
		result.data_byte   = (kind_s3 == KIND_BYTE) ? buf_s3[BUF_W-1 -: 8] : 8'd0;
		result.count_value = (kind_s3 == KIND_BYTE) ? '0 : count_s3;
		result.last        = (rem_s3 == REM_W'(1));
	end

	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> rem_s3 != '0 && rem_s3 <= REM_W'(4))
		else $error("hhp_emitter: held word with no bytes left");

	a_count_single: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && kind_s3 == KIND_COUNT |-> rem_s3 == REM_W'(1))
		else $error("hhp_emitter: count report spans several words");

	a_rem_step: assert property (@(posedge clk) disable iff (!arst_n)
		s3_shift |=> valid_s3 && rem_s3 == $past(rem_s3) - REM_W'(1))
		else $error("hhp_emitter: byte countdown skipped");

endmodule
